// File: rtl/two_stacks_one_array_defines.svh
// Assertion macros shared by the two-stack RTL.
`ifndef TWO_STACKS_ONE_ARRAY_DEFINES_SVH
`define TWO_STACKS_ONE_ARRAY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TSOA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tsoa_pkg.sv
// Shared constants, codes and types for the two-stack block.
package tsoa_pkg;

	localparam int TSOA_DEPTH   = 256;
	localparam int MIN_CAPACITY = 5;
	localparam int CFG_W        = 9;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int S_TDATA_W    = 40;
	localparam int M_TDATA_W    = 40;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOP     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOP_POP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// Controller to datapath strobes
	typedef struct packed {
		logic accept;
		logic cfg_write;
		logic load_out;
	} tsoa_cmd_t;

endpackage

// File: rtl/tsoa_ram.sv
// Generic single-port RAM with registered read data.
module tsoa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tsoa_ctrl.sv
// Controller: request sequencing and output register handshake.
module tsoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output tsoa_pkg::tsoa_cmd_t cmd
);
	import tsoa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOAD = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_out;

	// Handshake strobes; a capacity write wins over a request in the same cycle
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_LOAD) && (!out_valid_q || out_ready);

	assign cmd.accept    = in_valid && in_ready;
	assign cmd.cfg_write = cfg_valid && cfg_ready;
	assign cmd.load_out  = load_out;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/tsoa_dp.sv
// Datapath: stack pointers, capacity register, slot store and result register.
module tsoa_dp #(
	parameter int DEPTH = tsoa_pkg::TSOA_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tsoa_pkg::tsoa_cmd_t            cmd,
	input  logic [tsoa_pkg::S_TDATA_W-1:0] in_data,
	input  logic                           in_sel,
	input  logic [tsoa_pkg::CFG_W-1:0]     cfg_data,
	output logic [tsoa_pkg::M_TDATA_W-1:0] out_data
);
	import tsoa_pkg::*;

	localparam int PTR_W   = $clog2(DEPTH + 1);
	localparam int AW      = $clog2(DEPTH);
	localparam int CMP_W   = (PTR_W > CFG_W) ? PTR_W : CFG_W;
	localparam int RST_CAP = (DEPTH < 256) ? DEPTH : 256;
	localparam int PAD_W   = M_TDATA_W - DATA_W - STATUS_W;

	logic [PTR_W-1:0]    lower_q, upper_q, cap_q;
	logic [PTR_W-1:0]    lower_d, upper_d, cap_new;
	logic [CMD_W-1:0]    cmd_code;
	logic [DATA_W-1:0]   push_value;
	logic [CMP_W-1:0]    cfg_ext;
	logic                full, empty;
	logic                we, re;
	logic [PTR_W-1:0]    slot;
	logic [DATA_W-1:0]   rdata;
	logic [STATUS_W-1:0] status_d, status_pend_q, status_q;
	logic                rd_d, rd_pend_q;
	logic [DATA_W-1:0]   read_value_q;

	assign cmd_code   = in_data[CMD_W-1:0];
	assign push_value = in_data[CMD_W+DATA_W-1:CMD_W];

	// Clamp the written capacity into range
	assign cfg_ext = CMP_W'(cfg_data);
	always_comb begin
		if (cfg_ext < CMP_W'(MIN_CAPACITY)) begin
			cap_new = PTR_W'(MIN_CAPACITY);
		end else if (cfg_ext > CMP_W'(DEPTH)) begin
			cap_new = PTR_W'(DEPTH);
		end else begin
			cap_new = PTR_W'(cfg_ext);
		end
	end

	assign full  = (lower_q >= upper_q);
	assign empty = in_sel ? (upper_q >= cap_q) : (lower_q == '0);

	// Command decode: pointer updates, store access, pending status
	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		we       = 1'b0;
		re       = 1'b0;
		slot     = in_sel ? upper_q : lower_q - PTR_W'(1);
		status_d = STAT_OK;
		rd_d     = 1'b0;
		unique case (cmd_code)
			CMD_PUSH: begin
				if (full) begin
					status_d = STAT_FULL;
				end else if (in_sel) begin
					upper_d = upper_q - PTR_W'(1);
					slot    = upper_q - PTR_W'(1);
					we      = 1'b1;
				end else begin
					lower_d = lower_q + PTR_W'(1);
					slot    = lower_q;
					we      = 1'b1;
				end
			end
			CMD_POP, CMD_TOP, CMD_TOP_POP: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					if (cmd_code != CMD_POP) begin
						re   = 1'b1;
						rd_d = 1'b1;
					end
					if (cmd_code != CMD_TOP) begin
						if (in_sel) begin
							upper_d = upper_q + PTR_W'(1);
						end else begin
							lower_d = lower_q - PTR_W'(1);
						end
					end
				end
			end
			CMD_CLEAR: begin
				if (in_sel) begin
					upper_d = cap_q;
				end else begin
					lower_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Shared slot store
	tsoa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we && cmd.accept),
		.re    (re && cmd.accept),
		.addr  (slot[AW-1:0]),
		.wdata (push_value),
		.rdata (rdata)
	);

	// Pointers and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= PTR_W'(RST_CAP);
			cap_q   <= PTR_W'(RST_CAP);
		end else if (cmd.cfg_write) begin
			lower_q <= '0;
			upper_q <= cap_new;
			cap_q   <= cap_new;
		end else if (cmd.accept) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
		end
	end

	// Pending result and output register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_pend_q <= status_d;
			rd_pend_q     <= rd_d;
		end
		if (cmd.load_out) begin
			status_q     <= status_pend_q;
			read_value_q <= rd_pend_q ? rdata : '0;
		end
	end

	assign out_data = {PAD_W'(0), status_q, read_value_q};

endmodule

// File: rtl/two_stacks_one_array.sv
// Top level: two LIFO stacks sharing one slot store.
//
// Channel   Dir  Fields (low bit first)
// s_*       in   tdata: cmd[2:0], push_value[34:3]; tuser: stack_sel
// m_*       out  tdata: read_value[31:0], status[33:32]
// cfg_*     in   cfg_data: capacity[8:0]
//
// Each request is accepted in the idle state, which does the single store
// access; the load state moves the registered read data to the output once it is free.
// A new request may be accepted while the previous result waits on m_tready.
// s_tready stays low while cfg_valid is high, so a capacity write goes first.
// Reset empties both stacks, capacity min(256, DEPTH); store contents stay
// as they were, so there is no clearing pass.
`include "two_stacks_one_array_defines.svh"

module two_stacks_one_array #(
	parameter int DEPTH = tsoa_pkg::TSOA_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tsoa_pkg::S_TDATA_W-1:0] s_tdata,   // cmd, push_value, zero pad
	input  logic [0:0]                     s_tuser,   // stack_sel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tsoa_pkg::M_TDATA_W-1:0] m_tdata,   // read_value, status, zero pad
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsoa_pkg::CFG_W-1:0]     cfg_data   // capacity
);
	import tsoa_pkg::*;

	tsoa_cmd_t cmd;

	tsoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	tsoa_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.in_sel   (s_tuser[0]),
		.cfg_data (cfg_data),
		.out_data (m_tdata)
	);

	// One request in flight at a time
	`TSOA_ASSERT_NXT(a_one_in_flight, clk, arst_n, cmd.accept, !s_tready, "request accepted while busy")
	// Config port and input side are idle together
	`TSOA_ASSERT_IMP(a_idle_match, clk, arst_n, s_tready, cfg_ready, "config not ready while idle")
	// Output loads only from the busy state
	`TSOA_ASSERT_IMP(a_load_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result without request")

endmodule

// File: tb/sv/tb_two_stacks_one_array_checker.sv
// Checker for the two-stack block: watches all channels, predicts results and compares.
module stack_result_checker import tsoa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // cmd, push_value, zero pad
	input  logic [0:0]           s_tuser,   // stack_sel
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // read_value, status, zero pad
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,  // capacity
	output int                   fail_count,
	output int                   pending,
	output int                   checked_count,
	output int                   full_count,
	output int                   empty_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0]   read_value;
		logic [STATUS_W-1:0] status;
	} stack_result_t;

	// Shadow copy of the block state
	logic [CFG_W-1:0]  capacity_q;
	logic [CFG_W-1:0]  lower_cnt;
	logic [CFG_W-1:0]  upper_top;
	logic [DATA_W-1:0] slot_mem [TSOA_DEPTH];

	// Results still owed by the block, oldest first
	stack_result_t owed_results [$];

	// Out-of-range capacities are pulled into [MIN_CAPACITY, TSOA_DEPTH]
	function automatic logic [CFG_W-1:0] clamp_capacity(logic [CFG_W-1:0] v);
		if (v < MIN_CAPACITY)
			return CFG_W'(MIN_CAPACITY);
		if (v > TSOA_DEPTH)
			return CFG_W'(TSOA_DEPTH);
		return v;
	endfunction

	// Apply one stack command to the shadow state and return its result
	function automatic stack_result_t apply_stack_cmd(logic [CMD_W-1:0] cmd, logic upper,
			logic [DATA_W-1:0] val);
		stack_result_t r;
		logic is_empty;
		r = '0;
		r.status = STAT_OK;
		is_empty = upper ? (upper_top >= capacity_q) : (lower_cnt == '0);
		case (cmd)
			CMD_PUSH: begin
				// full only when the two tops meet
				if (lower_cnt >= upper_top) begin
					r.status = STAT_FULL;
				end else if (upper) begin
					upper_top = upper_top - 1'b1;
					slot_mem[upper_top] = val;
				end else begin
					slot_mem[lower_cnt] = val;
					lower_cnt = lower_cnt + 1'b1;
				end
			end
			CMD_POP, CMD_TOP, CMD_TOP_POP: begin
				if (is_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					if (cmd != CMD_POP)
						r.read_value = upper ? slot_mem[upper_top] : slot_mem[lower_cnt - 1'b1];
					if (cmd != CMD_TOP) begin
						if (upper)
							upper_top = upper_top + 1'b1;
						else
							lower_cnt = lower_cnt - 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				if (upper)
					upper_top = capacity_q;
				else
					lower_cnt = '0;
			end
			default: ;  // unused codes: no effect
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t got;
		stack_result_t want;
		if (!arst_n) begin
			capacity_q = CFG_W'(TSOA_DEPTH);
			lower_cnt = '0;
			upper_top = CFG_W'(TSOA_DEPTH);
			owed_results.delete();
			fail_count = 0;
			pending = 0;
			checked_count = 0;
			full_count = 0;
			empty_count = 0;
		end else begin
			// result side: compare against the oldest owed result
			if (m_tvalid && m_tready) begin
				got.read_value = m_tdata[DATA_W-1:0];
				got.status = m_tdata[DATA_W +: STATUS_W];
				if (owed_results.size() == 0) begin
					$error("unexpected result: read_value %0h status %0d",
						got.read_value, got.status);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					checked_count++;
					if (want.status == STAT_FULL)
						full_count++;
					if (want.status == STAT_EMPTY)
						empty_count++;
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0h, actual %0h",
							want.read_value, got.read_value);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
				end
			end
			// capacity write empties both stacks
			if (cfg_valid && cfg_ready) begin
				capacity_q = clamp_capacity(cfg_data);
				lower_cnt = '0;
				upper_top = capacity_q;
			end
			// request side
			if (s_tvalid && s_tready)
				owed_results.push_back(apply_stack_cmd(s_tdata[CMD_W-1:0], s_tuser[0],
					s_tdata[CMD_W +: DATA_W]));
			pending = owed_results.size();
		end
	end

endmodule

// File: tb/sv/tb_two_stacks_one_array.sv
// Testbench top for the two-stack block: stimulus, flow control, watchdog and verdict.
module tb_two_stacks_one_array import tsoa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = CMD_CLEAR + 1'b1;
	localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // cmd, push_value, zero pad
	logic [0:0]           s_tuser;   // stack_sel
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // read_value, status, zero pad
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;
	int empty_count;
	int cap_writes;
	int stall_cycles;
	bit idle_on;
	bit hold_req;

	typedef struct {
		logic [CFG_W-1:0] cap;
		int               n;
		int               push_pct;
		int               clear_pct;
		bit               idle;
		bit               hold;
		bit               drain;
	} phase_t;

	phase_t plan [11];

	two_stacks_one_array i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	stack_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.full_count    (full_count),
		.empty_count   (empty_count)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_two_stacks_one_array: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Result side flow control: random stall bursts, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(3)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// One request; returns at the falling edge after acceptance with s_tvalid low
	task automatic send_request(logic [CMD_W-1:0] cmd, logic sel, logic [DATA_W-1:0] val);
		if (idle_on && $urandom_range(5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(S_TDATA_W - DATA_W - CMD_W){1'b0}}, val, cmd};
		s_tuser = sel;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
	endtask

	// Capacity is only written with the block idle
	task automatic write_capacity(logic [CFG_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cap_writes++;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Random request mix: pushes, reads and pops, some clears, rare unused codes
	task automatic send_random(int push_pct, int clear_pct);
		int r;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(99);
		if (r < push_pct)
			cmd = CMD_PUSH;
		else if (r < 99 - clear_pct)
			cmd = CMD_POP + CMD_W'($urandom_range(2));
		else if (r < 99)
			cmd = CMD_CLEAR;
		else
			cmd = CMD_RSVD_FIRST + CMD_W'($urandom_range(2));
		send_request(cmd, 1'($urandom_range(1)), pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		cap_writes = 0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty reads, extreme values, every command, unused codes
		for (int s = 0; s < 2; s++) begin
			send_request(CMD_POP, 1'(s), '1);
			send_request(CMD_TOP, 1'(s), '1);
			send_request(CMD_TOP_POP, 1'(s), '1);
		end
		send_request(CMD_PUSH, 1'b0, VAL_MIN);
		send_request(CMD_PUSH, 1'b1, VAL_MAX);
		send_request(CMD_PUSH, 1'b0, '0);
		send_request(CMD_PUSH, 1'b1, '1);
		for (int s = 0; s < 2; s++)
			send_request(CMD_TOP, 1'(s), '0);
		for (int s = 0; s < 2; s++)
			send_request(CMD_TOP_POP, 1'(s), '0);
		for (int s = 0; s < 2; s++)
			send_request(CMD_POP, 1'(s), '0);
		for (int s = 0; s < 2; s++)
			send_request(CMD_PUSH, 1'(s), 32'h5A5A_A5A5);
		for (int s = 0; s < 2; s++)
			send_request(CMD_CLEAR, 1'(s), '1);
		for (int s = 0; s < 2; s++)
			send_request(CMD_TOP, 1'(s), '0);
		for (int c = CMD_RSVD_FIRST; c < 2 ** CMD_W; c++)
			send_request(CMD_W'(c), 1'(c), '1);

		// Random phases: cap, items, push %, clear %, idling, long hold-off, drain
		plan[0]  = '{9'd0,   150, 55, 2, 1'b1, 1'b0, 1'b0};
		plan[1]  = '{9'd5,   150, 60, 2, 1'b1, 1'b0, 1'b1};
		plan[2]  = '{9'd4,   100, 50, 3, 1'b1, 1'b0, 1'b0};
		plan[3]  = '{9'd511, 450, 86, 0, 1'b1, 1'b1, 1'b0};
		plan[4]  = '{9'd257, 100, 50, 4, 1'b1, 1'b0, 1'b0};
		plan[5]  = '{9'd256, 150, 40, 2, 1'b0, 1'b0, 1'b0};
		plan[6]  = '{9'd6,   150, 60, 2, 1'b1, 1'b0, 1'b0};
		plan[7]  = '{9'd17,  200, 65, 2, 1'b1, 1'b0, 1'b1};
		plan[8]  = '{CFG_W'($urandom_range(7, 255)), 200, 60, 2, 1'b1, 1'b0, 1'b0};
		plan[9]  = '{9'h0AA, 150, 55, 2, 1'b1, 1'b0, 1'b0};
		plan[10] = '{CFG_W'($urandom_range(5, 40)), 200, 55, 2, 1'b0, 1'b0, 1'b0};

		foreach (plan[p]) begin
			write_capacity(plan[p].cap);
			idle_on = plan[p].idle;
			for (int i = 0; i < plan[p].n; i++) begin
				// receiver holds off while requests keep coming, so the input stalls
				if (plan[p].hold && i == 60)
					hold_req = 1'b1;
				if (plan[p].drain && i == plan[p].n / 2)
					wait_drained();
				send_random(plan[p].push_pct, plan[p].clear_pct);
			end
		end

		// Drain and settle, then verdict
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d results over %0d capacity settings.", checked_count, cap_writes);
		$display("Rejections seen: %0d pushes on a full store, %0d reads of an empty stack.",
			full_count, empty_count);
		if (fail_count == 0 && pending == 0)
			$display("tb_two_stacks_one_array: PASS");
		else
			$display("tb_two_stacks_one_array: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tsoa_pkg.sv
rtl/tsoa_ram.sv
rtl/tsoa_ctrl.sv
rtl/tsoa_dp.sv
rtl/two_stacks_one_array.sv
tb/sv/tb_two_stacks_one_array_checker.sv
tb/sv/tb_two_stacks_one_array.sv
